// ===== sv/clns_pkg.sv =====
package clns_pkg;

	localparam logic [1:0] OP_CMD  = 2'd0;
	localparam logic [1:0] OP_DATA = 2'd1;
	localparam logic [1:0] OP_INIT = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] PH_SETUP = 2'd0;
	localparam logic [1:0] PH_PULSE = 2'd1;
	localparam logic [1:0] PH_HOLD  = 2'd2;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_BYTE = 4'd0;
	localparam pc_t PC_INIT = 4'd2;

	localparam logic [5:0] RS_BIT = 6'h10;
	localparam logic [5:0] EN_BIT = 6'h20;

	typedef enum logic [1:0] {
		NIB_CONST,
		NIB_HIGH,
		NIB_LOW
	} nib_sel_t;

	typedef enum logic {
		AFT_CONST,
		AFT_BYTE
	} aft_sel_t;

	typedef struct packed {
		nib_sel_t   nib_sel;
		logic [3:0] nib;
		logic [4:0] pre;
		aft_sel_t   aft_sel;
		logic [2:0] after;
		logic       fin;
	} ctrl_word_t;

	function automatic ctrl_word_t cw(input nib_sel_t sel, input logic [3:0] nib,
			input logic [4:0] pre, input aft_sel_t asel, input logic [2:0] after,
			input logic fin);
		ctrl_word_t w;
		w.nib_sel = sel;
		w.nib     = nib;
		w.pre     = pre;
		w.aft_sel = asel;
		w.after   = after;
		w.fin     = fin;
		return w;
	endfunction

	// one entry per nibble, three pin words each
	function automatic ctrl_word_t rom_word(input pc_t pc);
		ctrl_word_t w;
		case (pc)
			4'd0:    w = cw(NIB_HIGH,  4'h0, 5'd0,  AFT_CONST, 3'd0, 1'b0);
			4'd1:    w = cw(NIB_LOW,   4'h0, 5'd0,  AFT_BYTE,  3'd0, 1'b1);
			4'd2:    w = cw(NIB_CONST, 4'h3, 5'd20, AFT_CONST, 3'd5, 1'b0);
			4'd3:    w = cw(NIB_CONST, 4'h3, 5'd0,  AFT_CONST, 3'd1, 1'b0);
			4'd4:    w = cw(NIB_CONST, 4'h3, 5'd0,  AFT_CONST, 3'd1, 1'b0);
			4'd5:    w = cw(NIB_CONST, 4'h2, 5'd0,  AFT_CONST, 3'd1, 1'b0);
			4'd6:    w = cw(NIB_CONST, 4'h2, 5'd0,  AFT_CONST, 3'd0, 1'b0);
			4'd7:    w = cw(NIB_CONST, 4'h8, 5'd0,  AFT_CONST, 3'd1, 1'b0);
			4'd8:    w = cw(NIB_CONST, 4'h0, 5'd0,  AFT_CONST, 3'd0, 1'b0);
			4'd9:    w = cw(NIB_CONST, 4'h6, 5'd0,  AFT_CONST, 3'd1, 1'b0);
			4'd10:   w = cw(NIB_CONST, 4'h0, 5'd0,  AFT_CONST, 3'd0, 1'b0);
			4'd11:   w = cw(NIB_CONST, 4'h1, 5'd0,  AFT_CONST, 3'd2, 1'b0);
			4'd12:   w = cw(NIB_CONST, 4'h0, 5'd0,  AFT_CONST, 3'd0, 1'b0);
			4'd13:   w = cw(NIB_CONST, 4'hC, 5'd0,  AFT_CONST, 3'd1, 1'b1);
			default: w = cw(NIB_CONST, 4'h0, 5'd0,  AFT_CONST, 3'd0, 1'b1);
		endcase
		return w;
	endfunction

endpackage

// ===== sv/char_lcd_nibble_sequencer.sv =====
// first pin word: an accepted item is held in busy_q and pc_q, then its first word is registered into pin_q
// throughput: one pin word per cycle from the microcode step counter while out_stall does not hold the output
// a byte request gives 6 pin words, the init sequence 36 pin words
// in_stall is high while a run is in progress; an unused operation code is dropped
// reset (arst_n low, asynchronous) returns to idle with no pending item
module char_lcd_nibble_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [5:0] pin_word,
	output logic [4:0] wait_before_ms,
	output logic [2:0] wait_after_ms,
	output logic       last
);

	logic               busy_q;
	clns_pkg::pc_t      pc_q;
	logic [1:0]         phase_q;
	logic [7:0]         held_byte_q;
	logic [1:0]         held_op_q;
	logic               out_valid_q;
	logic [5:0]         pin_q;
	logic [4:0]         before_q;
	logic [2:0]         after_q;
	logic               last_q;

	clns_pkg::ctrl_word_t ctrl;
	logic               acc_in;
	logic               adv;
	logic [3:0]         nib;
	logic [5:0]         base;
	logic [2:0]         after_val;
	logic [5:0]         pin_d;
	logic [4:0]         before_d;
	logic [2:0]         after_d;
	logic               last_d;
	clns_pkg::pc_t      entry;

	assign in_stall = busy_q;
	assign acc_in   = in_valid && !busy_q;
	assign adv      = busy_q && (!out_valid_q || !out_stall);
	assign ctrl     = clns_pkg::rom_word(pc_q);

	always_comb begin
		case (operation)
			clns_pkg::OP_INIT: entry = clns_pkg::PC_INIT;
			default:           entry = clns_pkg::PC_BYTE;
		endcase
	end

	always_comb begin
		case (ctrl.nib_sel)
			clns_pkg::NIB_HIGH: nib = held_byte_q[7:4];
			clns_pkg::NIB_LOW:  nib = held_byte_q[3:0];
			default:            nib = ctrl.nib;
		endcase
		base = {2'b00, nib} | ((held_op_q == clns_pkg::OP_DATA) ? clns_pkg::RS_BIT : 6'h00);
		case (ctrl.aft_sel)
			clns_pkg::AFT_BYTE: after_val = ((held_op_q == clns_pkg::OP_DATA) ||
				(held_byte_q >= 8'd4)) ? 3'd1 : 3'd2;
			default:            after_val = ctrl.after;
		endcase
		pin_d    = base;
		before_d = 5'd0;
		after_d  = 3'd0;
		last_d   = 1'b0;
		case (phase_q)
			clns_pkg::PH_SETUP: before_d = ctrl.pre;
			clns_pkg::PH_PULSE: pin_d = base | clns_pkg::EN_BIT;
			default: begin
				after_d = after_val;
				last_d  = ctrl.fin;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			phase_q     <= clns_pkg::PH_SETUP;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_in) begin
				busy_q  <= (operation != clns_pkg::OP_NONE);
				pc_q    <= entry;
				phase_q <= clns_pkg::PH_SETUP;
			end else if (adv) begin
				if (phase_q == clns_pkg::PH_HOLD) begin
					phase_q <= clns_pkg::PH_SETUP;
					if (ctrl.fin) begin
						busy_q <= 1'b0;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			held_byte_q <= byte_value;
			held_op_q   <= operation;
		end
		if (adv) begin
			pin_q    <= pin_d;
			before_q <= before_d;
			after_q  <= after_d;
			last_q   <= last_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign pin_word       = pin_q;
	assign wait_before_ms = before_q;
	assign wait_after_ms  = after_q;
	assign last           = last_q;

endmodule

// ===== sv/clns_checker.sv =====
module clns_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] operation,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] pin_word,
	input logic [4:0] wait_before_ms,
	input logic [2:0] wait_after_ms,
	input logic       last
);

	// a real request blocks further items until its run is done
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation != clns_pkg::OP_NONE) |=> in_stall)
		else $error("request accepted without blocking the input");

	// nothing follows the final word of a run unless a new run is already going
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && !out_stall && !in_stall) |=> !out_valid)
		else $error("item shown after the final word of a run");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pin_word) && $stable(last)))
		else $error("stalled output item changed");

	// only the first init word waits before driving
	a_init_head: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && wait_before_ms != 5'd0) |-> (pin_word == 6'h03 && wait_before_ms == 5'd20))
		else $error("unexpected wait before a pin word");

	// final word has enable low and carries a wait
	a_last_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (!pin_word[5] && wait_after_ms != 3'd0))
		else $error("malformed final word");

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.operation      (operation),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.pin_word       (pin_word),
	.wait_before_ms (wait_before_ms),
	.wait_after_ms  (wait_after_ms),
	.last           (last)
);
